FILE: hw/rtl/psd_pkg.sv
package psd_pkg;

   localparam int COORD_WIDTH     = 16;
   localparam int PARAM_FRAC_BITS = 16;
   localparam int TOL_W           = 17;
   localparam int DIST_W          = 17;

   localparam int DIFF_W  = COORD_WIDTH + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int LEN_W   = PROD_W;
   localparam int DOT_W   = PROD_W + 1;
   localparam int REM_W   = LEN_W + 1;
   localparam int QUO_W   = PARAM_FRAC_BITS;
   localparam int PARAM_W = PARAM_FRAC_BITS + 1;
   localparam int PMUL_W  = PARAM_W + 1 + DIFF_W;
   localparam int OFF_W   = PMUL_W - PARAM_FRAC_BITS;
   localparam int DD_W    = OFF_W;
   localparam int SQ_W    = 2 * DD_W;
   localparam int SQW     = SQ_W;
   localparam int SQRT_STEPS = SQW / 2;
   localparam int ROOT_W  = SQRT_STEPS;
   localparam int SREM_W  = ROOT_W + 3;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] start_x;
      logic signed [COORD_WIDTH-1:0] start_y;
      logic signed [COORD_WIDTH-1:0] end_x;
      logic signed [COORD_WIDTH-1:0] end_y;
      logic signed [COORD_WIDTH-1:0] query_x;
      logic signed [COORD_WIDTH-1:0] query_y;
      logic [TOL_W-1:0]              tolerance;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              on_segment;
   } rsp_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic signed [DIFF_W-1:0] rx;
      logic signed [DIFF_W-1:0] ry;
      logic [TOL_W-1:0]         tol;
      logic                     force_one;
      logic [REM_W-1:0]         rem;
      logic [LEN_W-1:0]         len;
      logic [QUO_W-1:0]         quo;
   } div_type;

   typedef struct packed {
      logic [TOL_W-1:0]  tol;
      logic [SQW-1:0]    rad;
      logic [SREM_W-1:0] rem;
      logic [ROOT_W-1:0] root;
   } sqrt_type;

endpackage

FILE: hw/rtl/psd_if.sv
interface psd_req_if;
   logic              valid;
   logic              ready;
   psd_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface psd_rsp_if;
   logic              valid;
   logic              ready;
   psd_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/psd_div_cell.sv
module psd_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  psd_pkg::div_type  in_data,
   output logic              out_valid,
   output psd_pkg::div_type  out_data
);

   logic                         valid_ff;
   psd_pkg::div_type             data_ff;
   psd_pkg::div_type             data_in;
   logic [psd_pkg::REM_W-1:0]    shifted;
   logic                         ge;

   always_comb begin
      shifted = {in_data.rem[psd_pkg::REM_W-2:0], 1'b0};
      ge      = shifted >= {1'b0, in_data.len};
      data_in = in_data;
      data_in.rem = ge ? shifted - {1'b0, in_data.len} : shifted;
      data_in.quo = {in_data.quo[psd_pkg::QUO_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: hw/rtl/psd_sqrt_cell.sv
module psd_sqrt_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  psd_pkg::sqrt_type  in_data,
   output logic               out_valid,
   output psd_pkg::sqrt_type  out_data
);

   logic                          valid_ff;
   psd_pkg::sqrt_type             data_ff;
   psd_pkg::sqrt_type             data_in;
   logic [psd_pkg::SREM_W-1:0]    cur;
   logic [psd_pkg::SREM_W-1:0]    trial;
   logic                          ge;

   always_comb begin
      cur   = {in_data.rem[psd_pkg::SREM_W-3:0], in_data.rad[psd_pkg::SQW-1 -: 2]};
      trial = {1'b0, in_data.root, 2'b01};
      ge    = cur >= trial;
      data_in      = in_data;
      data_in.rem  = ge ? cur - trial : cur;
      data_in.root = {in_data.root[psd_pkg::ROOT_W-2:0], ge};
      data_in.rad  = {in_data.rad[psd_pkg::SQW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: hw/rtl/point_segment_distance_core.sv
// Point to segment distance: each transfer on req_bus gives a segment, a query point and an
// unsigned Q17.0 tolerance, and produces exactly one transfer on rsp_bus with the floored
// distance to the nearest segment point and a hit flag. The pipeline takes one item every
// cycle while rsp_bus does not stall. Its stages are three setup stages, a chain of 16
// divider cells (one quotient bit each), four stages for the nearest point and squared
// distance, a chain of 19 square root cells (one root bit each), and the output register.
// A stalled rsp_bus holds the whole pipeline.
module point_segment_distance_core (
   input  logic       clock,
   input  logic       reset,
   psd_req_if.sink    req_bus,
   psd_rsp_if.source  rsp_bus
);

   localparam int DW = psd_pkg::DIFF_W;

   logic en;
   logic out_valid_ff;
   psd_pkg::rsp_type out_data_ff;

   assign en = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = en;

   // Stage 1: differences.
   logic s1_valid_ff;
   logic signed [DW-1:0] s1_dx_ff, s1_dy_ff, s1_rx_ff, s1_ry_ff;
   logic [psd_pkg::TOL_W-1:0] s1_tol_ff;
   psd_pkg::req_type rq;
   assign rq = req_bus.payload;

   // Stage 2: products.
   logic s2_valid_ff;
   logic signed [DW-1:0] s2_dx_ff, s2_dy_ff, s2_rx_ff, s2_ry_ff;
   logic [psd_pkg::TOL_W-1:0] s2_tol_ff;
   logic signed [psd_pkg::PROD_W-1:0] s2_dxx_ff, s2_dyy_ff, s2_rdx_ff, s2_rdy_ff;

   // Stage 3: sums.
   logic s3_valid_ff;
   logic signed [DW-1:0] s3_dx_ff, s3_dy_ff, s3_rx_ff, s3_ry_ff;
   logic [psd_pkg::TOL_W-1:0] s3_tol_ff;
   logic [psd_pkg::LEN_W-1:0] s3_len_ff;
   logic signed [psd_pkg::DOT_W-1:0] s3_dot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_bus.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      if (en) begin
         s1_dx_ff  <= DW'(rq.end_x) - DW'(rq.start_x);
         s1_dy_ff  <= DW'(rq.end_y) - DW'(rq.start_y);
         s1_rx_ff  <= DW'(rq.query_x) - DW'(rq.start_x);
         s1_ry_ff  <= DW'(rq.query_y) - DW'(rq.start_y);
         s1_tol_ff <= rq.tolerance;

         s2_dx_ff  <= s1_dx_ff;
         s2_dy_ff  <= s1_dy_ff;
         s2_rx_ff  <= s1_rx_ff;
         s2_ry_ff  <= s1_ry_ff;
         s2_tol_ff <= s1_tol_ff;
         s2_dxx_ff <= s1_dx_ff * s1_dx_ff;
         s2_dyy_ff <= s1_dy_ff * s1_dy_ff;
         s2_rdx_ff <= s1_rx_ff * s1_dx_ff;
         s2_rdy_ff <= s1_ry_ff * s1_dy_ff;

         s3_dx_ff  <= s2_dx_ff;
         s3_dy_ff  <= s2_dy_ff;
         s3_rx_ff  <= s2_rx_ff;
         s3_ry_ff  <= s2_ry_ff;
         s3_tol_ff <= s2_tol_ff;
         s3_len_ff <= psd_pkg::LEN_W'(s2_dxx_ff) + psd_pkg::LEN_W'(s2_dyy_ff);
         s3_dot_ff <= psd_pkg::DOT_W'(s2_rdx_ff) + psd_pkg::DOT_W'(s2_rdy_ff);
      end
   end

   // Divider setup: a nonpositive dot product or a zero-length segment gives zero,
   // a dot product at or past the squared length gives one; both bypass the division.
   psd_pkg::div_type div_head;
   logic dot_pos, bypass_zero, bypass_one;

   always_comb begin
      dot_pos     = !s3_dot_ff[psd_pkg::DOT_W-1] && (s3_dot_ff != '0);
      bypass_zero = !dot_pos || (s3_len_ff == '0);
      bypass_one  = !bypass_zero && (s3_dot_ff[psd_pkg::LEN_W-1:0] >= s3_len_ff);
      div_head.dx  = s3_dx_ff;
      div_head.dy  = s3_dy_ff;
      div_head.rx  = s3_rx_ff;
      div_head.ry  = s3_ry_ff;
      div_head.tol = s3_tol_ff;
      div_head.force_one = bypass_one;
      div_head.quo = '0;
      if (bypass_zero || bypass_one) begin
         div_head.rem = '0;
         div_head.len = psd_pkg::LEN_W'(1);
      end else begin
         div_head.rem = {1'b0, s3_dot_ff[psd_pkg::LEN_W-1:0]};
         div_head.len = s3_len_ff;
      end
   end

   logic             div_valid [psd_pkg::QUO_W+1];
   psd_pkg::div_type div_data  [psd_pkg::QUO_W+1];
   assign div_valid[0] = s3_valid_ff;
   assign div_data[0]  = div_head;

   for (genvar i = 0; i < psd_pkg::QUO_W; i++) begin : g_div
      psd_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (div_valid[i]),
         .in_data   (div_data[i]),
         .out_valid (div_valid[i+1]),
         .out_data  (div_data[i+1])
      );
   end

   psd_pkg::div_type dv;
   logic [psd_pkg::PARAM_W-1:0] param;
   assign dv = div_data[psd_pkg::QUO_W];
   assign param = dv.force_one ? {1'b1, psd_pkg::QUO_W'(0)} : {1'b0, dv.quo};

   // Stage 5: offset products. Stage 6: differences to nearest point.
   // Stage 7: squares. Stage 8: squared distance.
   logic s5_valid_ff, s6_valid_ff, s7_valid_ff, s8_valid_ff;
   logic signed [psd_pkg::PMUL_W-1:0] s5_px_ff, s5_py_ff;
   logic signed [DW-1:0] s5_rx_ff, s5_ry_ff;
   logic [psd_pkg::TOL_W-1:0] s5_tol_ff, s6_tol_ff, s7_tol_ff, s8_tol_ff;
   logic signed [psd_pkg::DD_W-1:0] s6_ddx_ff, s6_ddy_ff;
   logic signed [psd_pkg::SQ_W-1:0] s7_sx_ff, s7_sy_ff;
   logic [psd_pkg::SQW-1:0] s8_d2_ff;
   logic signed [psd_pkg::OFF_W-1:0] offx, offy;

   assign offx = s5_px_ff[psd_pkg::PMUL_W-1:psd_pkg::PARAM_FRAC_BITS];
   assign offy = s5_py_ff[psd_pkg::PMUL_W-1:psd_pkg::PARAM_FRAC_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
      end else if (en) begin
         s5_valid_ff <= div_valid[psd_pkg::QUO_W];
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= s6_valid_ff;
         s8_valid_ff <= s7_valid_ff;
      end
      if (en) begin
         s5_px_ff  <= $signed({1'b0, param}) * dv.dx;
         s5_py_ff  <= $signed({1'b0, param}) * dv.dy;
         s5_rx_ff  <= dv.rx;
         s5_ry_ff  <= dv.ry;
         s5_tol_ff <= dv.tol;

         s6_ddx_ff <= psd_pkg::DD_W'(s5_rx_ff) - offx;
         s6_ddy_ff <= psd_pkg::DD_W'(s5_ry_ff) - offy;
         s6_tol_ff <= s5_tol_ff;

         s7_sx_ff  <= s6_ddx_ff * s6_ddx_ff;
         s7_sy_ff  <= s6_ddy_ff * s6_ddy_ff;
         s7_tol_ff <= s6_tol_ff;

         s8_d2_ff  <= psd_pkg::SQW'(s7_sx_ff[psd_pkg::SQ_W-2:0])
                    + psd_pkg::SQW'(s7_sy_ff[psd_pkg::SQ_W-2:0]);
         s8_tol_ff <= s7_tol_ff;
      end
   end

   logic              sq_valid [psd_pkg::SQRT_STEPS+1];
   psd_pkg::sqrt_type sq_data  [psd_pkg::SQRT_STEPS+1];
   assign sq_valid[0]     = s8_valid_ff;
   assign sq_data[0].tol  = s8_tol_ff;
   assign sq_data[0].rad  = s8_d2_ff;
   assign sq_data[0].rem  = '0;
   assign sq_data[0].root = '0;

   for (genvar i = 0; i < psd_pkg::SQRT_STEPS; i++) begin : g_sqrt
      psd_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sq_valid[i]),
         .in_data   (sq_data[i]),
         .out_valid (sq_valid[i+1]),
         .out_data  (sq_data[i+1])
      );
   end

   psd_pkg::sqrt_type sr;
   logic [psd_pkg::DIST_W-1:0] dist_val;
   assign sr   = sq_data[psd_pkg::SQRT_STEPS];
   assign dist_val = (sr.root > psd_pkg::ROOT_W'(psd_pkg::DIST_MAX)) ? psd_pkg::DIST_MAX
                   : sr.root[psd_pkg::DIST_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= sq_valid[psd_pkg::SQRT_STEPS];
      end
      if (en) begin
         out_data_ff.distance   <= dist_val;
         out_data_ff.on_segment <= dist_val < sr.tol;
      end
   end

   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.payload = out_data_ff;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1900;

   typedef struct {
      psd_pkg::req_type req;
      bit      known;
      psd_pkg::rsp_type rsp;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycles = 0;
   int   mismatches = 0;
   int   stall_mode = 0;
   psd_pkg::rsp_type expected_rsps[$];
   stim_row_type stim_table[$];

   psd_req_if req_bus();
   psd_rsp_if rsp_bus();

   point_segment_distance_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root = 0;
      longint unsigned bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic psd_pkg::rsp_type predict_distance(psd_pkg::req_type r);
      longint dx, dy, rx, ry, dot, len2, frac, offx, offy, ddx, ddy;
      longint unsigned dsq, dist_val;
      psd_pkg::rsp_type o;
      dx = longint'(r.end_x) - longint'(r.start_x);
      dy = longint'(r.end_y) - longint'(r.start_y);
      rx = longint'(r.query_x) - longint'(r.start_x);
      ry = longint'(r.query_y) - longint'(r.start_y);
      len2 = dx * dx + dy * dy;
      dot = rx * dx + ry * dy;
      if (dot <= 0 || len2 == 0) frac = 0;
      else if (dot >= len2) frac = longint'(1) << psd_pkg::PARAM_FRAC_BITS;
      else frac = (dot << psd_pkg::PARAM_FRAC_BITS) / len2;
      offx = (frac * dx) >>> psd_pkg::PARAM_FRAC_BITS;
      offy = (frac * dy) >>> psd_pkg::PARAM_FRAC_BITS;
      ddx = rx - offx;
      ddy = ry - offy;
      dsq = longint'(ddx * ddx) + longint'(ddy * ddy);
      dist_val = int_sqrt(dsq);
      if (dist_val > psd_pkg::DIST_MAX) dist_val = psd_pkg::DIST_MAX;
      o.distance = dist_val[psd_pkg::DIST_W-1:0];
      o.on_segment = dist_val < r.tolerance;
      return o;
   endfunction

   function automatic psd_pkg::req_type make_req(int sx, int sy, int ex, int ey, int qx,
                                                 int qy, int tol);
      psd_pkg::req_type r;
      r.start_x = psd_pkg::COORD_WIDTH'(sx);
      r.start_y = psd_pkg::COORD_WIDTH'(sy);
      r.end_x = psd_pkg::COORD_WIDTH'(ex);
      r.end_y = psd_pkg::COORD_WIDTH'(ey);
      r.query_x = psd_pkg::COORD_WIDTH'(qx);
      r.query_y = psd_pkg::COORD_WIDTH'(qy);
      r.tolerance = psd_pkg::TOL_W'(tol);
      return r;
   endfunction

   function automatic int rand_coord(int center, int spread);
      int v;
      v = center + $urandom_range(2 * spread, 0) - spread;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   function automatic psd_pkg::req_type random_req();
      psd_pkg::req_type r;
      psd_pkg::rsp_type p;
      int kind, spread, cx, cy;
      kind = $urandom_range(9, 0);
      spread = (kind < 3) ? 32767 : (kind < 6) ? 2000 : 64;
      cx = $urandom_range(65535, 0) - 32768;
      cy = $urandom_range(65535, 0) - 32768;
      r = make_req(rand_coord(cx, spread), rand_coord(cy, spread), rand_coord(cx, spread),
                   rand_coord(cy, spread), rand_coord(cx, spread), rand_coord(cy, spread),
                   $urandom_range(131071, 0));
      if (kind == 6) begin
         r.end_x = r.start_x;
         r.end_y = r.start_y;
      end else if (kind == 7) begin
         r.query_x = psd_pkg::COORD_WIDTH'(r.end_x + $urandom_range(8, 0) - 4);
         r.query_y = psd_pkg::COORD_WIDTH'(r.end_y + $urandom_range(8, 0) - 4);
      end else if (kind == 8) begin
         r = make_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      if ($urandom_range(2, 0) == 0) begin
         p = predict_distance(r);
         r.tolerance = psd_pkg::TOL_W'(p.distance + $urandom_range(2, 0) - 1);
      end
      return r;
   endfunction

   task automatic send_item(psd_pkg::req_type r);
      int gap;
      gap = ($urandom_range(19, 0) == 0) ? $urandom_range(40, 5) : $urandom_range(2, 0);
      if ($urandom_range(3, 0) == 0) gap = 0;
      repeat (gap) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.payload <= r;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic add_row(psd_pkg::req_type r, bit known, int dist_val, bit hit);
      stim_row_type row;
      row.req = r;
      row.known = known;
      row.rsp.distance = psd_pkg::DIST_W'(dist_val);
      row.rsp.on_segment = hit;
      stim_table.push_back(row);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
      if ($urandom_range(199, 0) == 0) stall_mode <= $urandom_range(3, 0);
      case (stall_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= $urandom_range(3, 0) != 0;
         2: rsp_bus.ready <= $urandom_range(1, 0) != 0;
         default: rsp_bus.ready <= $urandom_range(15, 0) == 0;
      endcase
      if (!reset && req_bus.valid && req_bus.ready)
         expected_rsps.push_back(predict_distance(req_bus.payload));
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected transfer: %p", rsp_bus.payload);
         end else begin
            if (rsp_bus.payload.distance !== expected_rsps[0].distance ||
                rsp_bus.payload.on_segment !== expected_rsps[0].on_segment) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected distance %0d hit %0d, got distance %0d hit %0d",
                           expected_rsps[0].distance, expected_rsps[0].on_segment,
                           rsp_bus.payload.distance, rsp_bus.payload.on_segment);
            end
            void'(expected_rsps.pop_front());
         end
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      add_row(make_req(0, 0, 0, 0, 0, 0, 0), 1, 0, 0);
      add_row(make_req(0, 0, 0, 0, 0, 0, 1), 1, 0, 1);
      add_row(make_req(0, 0, 0, 0, 48, 64, 81), 1, 80, 1);
      add_row(make_req(0, 0, 0, 0, 48, 64, 80), 1, 80, 0);
      add_row(make_req(0, 0, 160, 0, 80, 32, 131071), 1, 32, 1);
      add_row(make_req(0, 0, 160, 0, -48, 64, 0), 1, 80, 0);
      add_row(make_req(0, 0, 160, 0, 208, 64, 0), 1, 80, 0);
      add_row(make_req(0, 0, 160, 0, 160, 0, 0), 1, 0, 0);
      add_row(make_req(-32768, -32768, -32768, -32768, 32767, 32767, 131071), 0, 0, 0);
      add_row(make_req(-32768, -32768, 32767, 32767, 32767, -32768, 131071), 0, 0, 0);
      add_row(make_req(32767, -32768, -32768, 32767, -32768, -32768, 0), 0, 0, 0);
      add_row(make_req(-32768, 32767, 32767, -32768, 32767, 32767, 65536), 0, 0, 0);
      add_row(make_req(0, 0, 3, 7, 1, 2, 5), 0, 0, 0);
      add_row(make_req(5, -3, -7, 11, 100, -200, 300), 0, 0, 0);
      add_row(make_req(0, 0, -160, -32, -1, -1, 2), 0, 0, 0);
      add_row(make_req(100, 100, -100, 100, 0, 0, 100), 0, 0, 0);
      add_row(make_req(32767, 32767, 32767, 32767, -32768, -32768, 0), 0, 0, 0);

      foreach (stim_table[i]) begin
         if (stim_table[i].known && predict_distance(stim_table[i].req) !== stim_table[i].rsp)
         begin
            mismatches++;
            if (mismatches <= 10) $display("Table row %0d disagrees with predictor", i);
         end
         send_item(stim_table[i].req);
      end
      req_bus.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
            while (expected_rsps.size() != 0) @(posedge clock);
         end
         send_item(random_req());
      end
      req_bus.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
